// ===== hdl/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the serial stick command decoder.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Number of characters that follow an argument command letter.
  localparam int ArgDigits = 4;

  localparam int StickW = 15;   // width of the signed stick command values
  localparam int AccumW = 14;   // width of the argument magnitude
  localparam int CountW = 17;   // width of the hold counter
  localparam int ChanW  = 12;   // width of a live receiver channel

  localparam logic [ChanW-1:0]    CenterReset   = 12'd1502;
  localparam logic [StickW-1:0]   FloorReset    = 15'd1700;
  localparam logic [StickW-1:0]   ThrottleReset = 15'd1100;
  localparam logic [AccumW-1:0]   AccumMax      = 14'd9999;
  localparam logic [CountW-1:0]   CountMax      = '1;

  localparam logic [9:0]  AdjustmentReset  = 10'd100;
  localparam logic [15:0] HoldLimitReset   = 16'd100;
  localparam logic [11:0] ArmThrottleReset = 12'd1100;

  // Command letters.
  localparam logic [7:0] ChArm    = 8'h61;  // 'a'
  localparam logic [7:0] ChClear  = 8'h71;  // 'q'
  localparam logic [7:0] ChCenter = 8'h73;  // 's'
  localparam logic [7:0] ChThr    = 8'h74;  // 't'
  localparam logic [7:0] ChRoll   = 8'h72;  // 'r'
  localparam logic [7:0] ChPitch  = 8'h70;  // 'p'
  localparam logic [7:0] ChFloor  = 8'h6D;  // 'm'
  localparam logic [7:0] ChNorth  = 8'h78;  // 'x'
  localparam logic [7:0] ChEast   = 8'h7A;  // 'z'
  localparam logic [7:0] ChSouth  = 8'h79;  // 'y'
  localparam logic [7:0] ChWest   = 8'h75;  // 'u'

  // Argument characters.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Configuration register indexes.
  localparam logic [1:0] RegAdjustment  = 2'd0;
  localparam logic [1:0] RegHoldLimit   = 2'd1;
  localparam logic [1:0] RegArmThrottle = 2'd2;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_THROTTLE = 3'd1,
    TGT_ROLL     = 3'd2,
    TGT_PITCH    = 3'd3,
    TGT_FLOOR    = 3'd4
  } target_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic              negative;
    logic [AccumW-1:0] accum;
  } arg_state_t;

  typedef struct packed {
    logic [9:0]  adjustment;
    logic [15:0] hold_limit;
    logic [11:0] arm_throttle;
  } cfg_t;

  typedef struct packed {
    logic signed [StickW-1:0] pitch;
    logic signed [StickW-1:0] roll;
    logic [3:0]               dir_flags;
    logic [CountW-1:0]        hold_count;
  } tick_t;

endpackage

// ===== hdl/ssc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_in_if
// Request channel carrying received bytes and control loop ticks.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  rx_byte;
  logic [11:0] rc_pitch;
  logic [11:0] rc_roll;

  modport source (output valid, mode, rx_byte, rc_pitch, rc_roll, input ready);
  modport sink   (input valid, mode, rx_byte, rc_pitch, rc_roll, output ready);
endinterface

// ===== hdl/ssc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_out_if
// Result channel carrying the stick command values.
// ----------------------------------------------------------------------------
interface ssc_out_if;
  logic               valid;
  logic               ready;
  logic               armed;
  logic signed [14:0] throttle;
  logic signed [14:0] pitch;
  logic signed [14:0] roll;
  logic               clear_store;
  logic [3:0]         directions;

  modport source (output valid, armed, throttle, pitch, roll, clear_store, directions,
                  input ready);
  modport sink   (input valid, armed, throttle, pitch, roll, clear_store, directions,
                  output ready);
endinterface

// ===== hdl/serial_stick_command_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_stick_command_decoder_top
// Decodes one-letter serial commands and loop ticks into stick commands.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the cmd channel (valid/ready). A request with
// mode 0 carries one received serial byte; a request with mode 1 is a
// control loop tick. Every request produces exactly one result on the stick
// channel, showing armed, throttle, pitch, roll, directions and the one-shot
// clear_store flag as they stand after that request.
// A request is captured in the input register; decode and state update work
// from there and load the result register and the state together. One
// request is taken every cycle while the receiver does not stall.
// The state update sits between the input register and the result
// register, so back-to-back requests see each other's effects.
// When the receiver stalls, the result register holds its value and the
// input register holds the next request; cmd.ready drops only when both are
// full and the receiver is not taking the result.
// The three configuration registers are written over the APB-style port and
// should be changed only while no request is in flight.
// Reset (rst, synchronous) empties both registers, disarms, cancels any
// pending argument and restores centres 1502, throttle 1100, floor 1700 and
// the configuration defaults.
// ----------------------------------------------------------------------------
module serial_stick_command_decoder_top (
  input  logic        clk,
  input  logic        rst,
  ssc_in_if.sink      cmd,
  ssc_out_if.source   stick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssc_pkg::*;

  cfg_t cfg;

  ssc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic        in_valid;
  logic        in_mode;
  logic [7:0]  in_byte;
  logic [11:0] in_pitch;
  logic [11:0] in_roll;
  logic        advance;

  // The input register moves on whenever the result register is free or
  // is being emptied in the same cycle.
  assign advance   = in_valid && (!stick.valid || stick.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_mode  <= cmd.mode;
      in_byte  <= cmd.rx_byte;
      in_pitch <= cmd.rc_pitch;
      in_roll  <= cmd.rc_roll;
    end
  end

  // Decoder state.
  logic                     armed_flag,     armed_flag_next;
  target_t                  pending_target, pending_target_next;
  logic [2:0]               bytes_left,     bytes_left_next;
  arg_state_t               arg,            arg_next;
  logic [3:0]               dir_flags,      dir_flags_next;
  logic [CountW-1:0]        hold_count,     hold_count_next;
  logic [ChanW-1:0]         center_pitch,   center_pitch_next;
  logic [ChanW-1:0]         center_roll,    center_roll_next;
  logic signed [StickW-1:0] floor_throttle, floor_throttle_next;
  logic signed [StickW-1:0] throttle_reg,   throttle_reg_next;
  logic signed [StickW-1:0] pitch_reg,      pitch_reg_next;
  logic signed [StickW-1:0] roll_reg,       roll_reg_next;
  logic                     clear_next;

  arg_state_t               arg_parsed;
  tick_t                    tick_res;
  logic signed [StickW-1:0] arg_value;
  logic [2:0]               bytes_dec;

  ssc_arg_parse u_parse (
    .cur (arg),
    .ch  (in_byte),
    .nxt (arg_parsed)
  );

  ssc_tick u_tick (
    .center_pitch (center_pitch),
    .center_roll  (center_roll),
    .dir_flags    (dir_flags),
    .hold_count   (hold_count),
    .cfg          (cfg),
    .res          (tick_res)
  );

  assign bytes_dec = bytes_left - 3'd1;
  // The argument value is taken after this character has been parsed.
  assign arg_value = arg_parsed.negative ? -signed'(StickW'(arg_parsed.accum))
                                         :  signed'(StickW'(arg_parsed.accum));

  always_comb begin
    armed_flag_next     = armed_flag;
    pending_target_next = pending_target;
    bytes_left_next     = bytes_left;
    arg_next            = arg;
    dir_flags_next      = dir_flags;
    hold_count_next     = hold_count;
    center_pitch_next   = center_pitch;
    center_roll_next    = center_roll;
    floor_throttle_next = floor_throttle;
    throttle_reg_next   = throttle_reg;
    pitch_reg_next      = pitch_reg;
    roll_reg_next       = roll_reg;
    clear_next          = 1'b0;

    if (!in_mode) begin
      if ((pending_target != TGT_NONE) && (bytes_left != 3'd0)) begin
        // Argument character: letters here are never commands.
        arg_next        = arg_parsed;
        bytes_left_next = bytes_dec;
        if (bytes_dec == 3'd0) begin
          case (pending_target)
            TGT_THROTTLE: throttle_reg_next = (arg_value > floor_throttle) ? arg_value
                                                                         : floor_throttle;
            TGT_ROLL:     roll_reg_next       = arg_value;
            TGT_PITCH:    pitch_reg_next      = arg_value;
            TGT_FLOOR:    floor_throttle_next = arg_value;
            default: ;
          endcase
          pending_target_next = TGT_NONE;
        end
      end else begin
        case (in_byte)
          ChArm: begin
            armed_flag_next   = !armed_flag;
            throttle_reg_next = signed'(StickW'(cfg.arm_throttle));
          end
          ChClear: clear_next = 1'b1;
          ChCenter: begin
            center_pitch_next = in_pitch;
            center_roll_next  = in_roll;
            pitch_reg_next    = signed'(StickW'(in_pitch));
            roll_reg_next     = signed'(StickW'(in_roll));
          end
          ChThr, ChRoll, ChPitch, ChFloor: begin
            // Argument letters are ignored while disarmed.
            if (armed_flag) begin
              case (in_byte)
                ChThr:   pending_target_next = TGT_THROTTLE;
                ChRoll:  pending_target_next = TGT_ROLL;
                ChPitch: pending_target_next = TGT_PITCH;
                default: pending_target_next = TGT_FLOOR;
              endcase
              bytes_left_next   = 3'(ArgDigits);
              arg_next.phase    = PH_SKIP;
              arg_next.negative = 1'b0;
              arg_next.accum    = '0;
            end
          end
          ChNorth: begin
            dir_flags_next  = dir_flags | 4'b0001;
            hold_count_next = '0;
          end
          ChEast: begin
            dir_flags_next  = dir_flags | 4'b0010;
            hold_count_next = '0;
          end
          ChSouth: begin
            dir_flags_next  = dir_flags | 4'b0100;
            hold_count_next = '0;
          end
          ChWest: begin
            dir_flags_next  = dir_flags | 4'b1000;
            hold_count_next = '0;
          end
          default: ;
        endcase
      end
    end else begin
      // Tick: deflect from the centres, then run the hold timer.
      pitch_reg_next  = tick_res.pitch;
      roll_reg_next   = tick_res.roll;
      dir_flags_next  = tick_res.dir_flags;
      hold_count_next = tick_res.hold_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag     <= 1'b0;
      pending_target <= TGT_NONE;
      bytes_left     <= 3'd0;
      arg.phase      <= PH_SKIP;
      arg.negative   <= 1'b0;
      arg.accum      <= '0;
      dir_flags      <= 4'd0;
      hold_count     <= '0;
      center_pitch   <= CenterReset;
      center_roll    <= CenterReset;
      floor_throttle <= FloorReset;
      throttle_reg   <= ThrottleReset;
      pitch_reg      <= StickW'(CenterReset);
      roll_reg       <= StickW'(CenterReset);
    end else if (advance) begin
      armed_flag     <= armed_flag_next;
      pending_target <= pending_target_next;
      bytes_left     <= bytes_left_next;
      arg            <= arg_next;
      dir_flags      <= dir_flags_next;
      hold_count     <= hold_count_next;
      center_pitch   <= center_pitch_next;
      center_roll    <= center_roll_next;
      floor_throttle <= floor_throttle_next;
      throttle_reg   <= throttle_reg_next;
      pitch_reg      <= pitch_reg_next;
      roll_reg       <= roll_reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stick.valid <= 1'b0;
    end else if (advance) begin
      stick.valid <= 1'b1;
    end else if (stick.ready) begin
      stick.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stick.armed       <= armed_flag_next;
      stick.throttle    <= throttle_reg_next;
      stick.pitch       <= pitch_reg_next;
      stick.roll        <= roll_reg_next;
      stick.clear_store <= clear_next;
      stick.directions  <= dir_flags_next;
    end
  end
endmodule

// ===== hdl/ssc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_cfg_regs
// APB-style configuration registers: adjustment, hold limit, arm throttle.
// ----------------------------------------------------------------------------
module ssc_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output ssc_pkg::cfg_t cfg
);
  import ssc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adjustment   <= AdjustmentReset;
      cfg.hold_limit   <= HoldLimitReset;
      cfg.arm_throttle <= ArmThrottleReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegAdjustment:  cfg.adjustment   <= pwdata[9:0];
        RegHoldLimit:   cfg.hold_limit   <= pwdata[15:0];
        RegArmThrottle: cfg.arm_throttle <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegAdjustment:  prdata = {22'd0, cfg.adjustment};
      RegHoldLimit:   prdata = {16'd0, cfg.hold_limit};
      RegArmThrottle: prdata = {20'd0, cfg.arm_throttle};
      default:        prdata = 32'd0;
    endcase
  end
endmodule

// ===== hdl/ssc_arg_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_arg_parse
// One step of the numeric argument parser: white space, sign, then digits.
// ----------------------------------------------------------------------------
module ssc_arg_parse (
  input  ssc_pkg::arg_state_t cur,
  input  logic [7:0]          ch,
  output ssc_pkg::arg_state_t nxt
);
  import ssc_pkg::*;

  logic              is_digit;
  logic              is_white;
  logic [3:0]        digit;
  logic [CountW-1:0] acc_wide;

  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign is_white = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
  assign digit    = 4'(ch - ChZero);
  // Multiply by ten as two shifts, then add the new digit.
  assign acc_wide = (CountW'(cur.accum) << 3) + (CountW'(cur.accum) << 1)
                  + CountW'(digit);

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_SKIP: begin
        if (is_white) begin
          nxt = cur;
        end else if ((ch == ChPlus) || (ch == ChMinus)) begin
          nxt.negative = (ch == ChMinus);
          nxt.phase    = PH_DIGITS;
        end else if (is_digit) begin
          nxt.accum = AccumW'(digit);
          nxt.phase = PH_DIGITS;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          nxt.accum = (acc_wide > CountW'(AccumMax)) ? AccumMax : acc_wide[AccumW-1:0];
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: nxt = cur;
    endcase
  end
endmodule

// ===== hdl/ssc_tick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_tick
// Control loop tick: deflected pitch and roll, and the direction hold timer.
// ----------------------------------------------------------------------------
module ssc_tick (
  input  logic [11:0]              center_pitch,
  input  logic [11:0]              center_roll,
  input  logic [3:0]               dir_flags,
  input  logic [16:0]              hold_count,
  input  ssc_pkg::cfg_t            cfg,
  output ssc_pkg::tick_t           res
);
  import ssc_pkg::*;

  logic signed [StickW-1:0] adj;
  logic signed [StickW-1:0] cp;
  logic signed [StickW-1:0] cr;
  logic                     expired;

  assign adj = signed'(StickW'(cfg.adjustment));
  assign cp  = signed'(StickW'(center_pitch));
  assign cr  = signed'(StickW'(center_roll));
  assign expired = hold_count > CountW'(cfg.hold_limit);

  always_comb begin
    // South raises pitch, north lowers it; west raises roll, east lowers it.
    res.pitch = cp + (dir_flags[2] ? adj : '0) - (dir_flags[0] ? adj : '0);
    res.roll  = cr + (dir_flags[3] ? adj : '0) - (dir_flags[1] ? adj : '0);
    if (expired) begin
      res.dir_flags  = 4'd0;
      res.hold_count = CountW'(1);
    end else begin
      res.dir_flags  = dir_flags;
      res.hold_count = (hold_count == CountMax) ? hold_count : hold_count + 1'b1;
    end
  end
endmodule

// ===== hdl/ssc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the serial stick command decoder, bound to its top.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic stick_valid,
  input logic stick_ready
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stick_valid && !stick_ready |=> stick_valid)
    else $error("result withdrawn while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !stick_valid)
    else $error("result valid straight after reset");

  // With the result register empty, requests are always taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !stick_valid |-> cmd_ready)
    else $error("request refused with empty result register");

  // A request that is followed by a free receiver yields a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) ##1 stick_ready |=> stick_valid)
    else $error("accepted request produced no result");

endmodule

bind serial_stick_command_decoder_top ssc_checker u_ssc_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .stick_valid (stick.valid),
  .stick_ready (stick.ready)
);

// ===== tb/sv/tb_serial_stick_command_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_stick_command_decoder_top
// Self-checking bench for the serial stick command decoder.
// ----------------------------------------------------------------------------
// A short directed table (reset state, every command letter but r, a disarmed
// argument letter, white space, a sign and a command letter inside an
// argument) is followed by random phases, each run under its own register
// setting. Every accepted request is run through a behavioural predictor,
// and each result on the stick channel is compared field by field with the
// oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_serial_stick_command_decoder_top;
  import ssc_pkg::*;

  localparam int ClkHalf     = 6;    // 12 ns period
  localparam int ResetCycles = 11;
  localparam int IdleLimit   = 400;  // cycles without any transfer before giving up
  localparam int PrintCap    = 200;  // keeps a broken design from flooding the log
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 190;

  // One result of the block, in the order of the output channel's fields.
  typedef struct packed {
    logic               armed;
    logic signed [14:0] throttle;
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic               clear_store;
    logic [3:0]         directions;
  } stick_t;

  // One request. Where typed is set, want holds the result read straight off
  // the specification; otherwise the predictor supplies the expectation.
  typedef struct packed {
    logic        mode;
    logic [7:0]  ch;
    logic [11:0] rp;
    logic [11:0] rr;
    logic        typed;
    stick_t      want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ssc_in_if  cmd ();
  ssc_out_if stick ();

  serial_stick_command_decoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stick   (stick),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the block's registers and is brought to the
  // reset values once, at the start, as the block is reset only once.
  // --------------------------------------------------------------------------
  cfg_t     cfg_now       = '{adjustment: AdjustmentReset, hold_limit: HoldLimitReset,
                              arm_throttle: ArmThrottleReset};
  logic     st_armed      = 1'b0;
  target_t  st_target     = TGT_NONE;
  int       st_left       = 0;
  phase_t   st_phase      = PH_SKIP;
  logic     st_neg        = 1'b0;
  int       st_accum      = 0;
  logic [3:0] st_dirs     = 4'd0;
  int       st_hold       = 0;
  int       centre_pitch  = int'(CenterReset);
  int       centre_roll   = int'(CenterReset);
  int       floor_thr     = int'(FloorReset);
  int       thr_now       = int'(ThrottleReset);
  int       pitch_now     = int'(CenterReset);
  int       roll_now      = int'(CenterReset);

  stick_t   stick_expected [$];
  int       mismatches    = 0;
  int       results_seen  = 0;
  int       idle_cycles   = 0;
  int       src_calm      = 0;
  int       sink_calm     = 0;
  step_t    directed_steps [25];

  // Opens an argument for one of the four argument letters. A disarmed
  // block ignores the letter altogether.
  function automatic void open_arg(input target_t t);
    if (st_armed) begin
      st_target = t;
      st_left   = ArgDigits;
      st_phase  = PH_SKIP;
      st_neg    = 1'b0;
      st_accum  = 0;
    end
  endfunction

  // Advances the predictor by one accepted request and returns the result
  // that the block is expected to produce for it.
  function automatic stick_t predict_stick(input step_t s);
    stick_t r;
    logic   clr;
    logic   digit;
    logic   white;
    int     v;
    int     adj;
    clr = 1'b0;
    if (!s.mode) begin
      if (st_target != TGT_NONE && st_left != 0) begin
        // Argument character: parsed like atol, even if it is a command letter.
        digit = (s.ch >= ChZero) && (s.ch <= ChNine);
        white = (s.ch == ChSpace) || (s.ch >= ChTab && s.ch <= ChCr);
        case (st_phase)
          PH_SKIP: begin
            if (!white) begin
              if (s.ch == ChPlus || s.ch == ChMinus) begin
                st_neg   = (s.ch == ChMinus);
                st_phase = PH_DIGITS;
              end else if (digit) begin
                st_accum = int'(s.ch) - int'(ChZero);
                st_phase = PH_DIGITS;
              end else begin
                st_phase = PH_DONE;
              end
            end
          end
          PH_DIGITS: begin
            if (digit) begin
              st_accum = st_accum * 10 + int'(s.ch) - int'(ChZero);
              if (st_accum > int'(AccumMax)) st_accum = int'(AccumMax);
            end else begin
              st_phase = PH_DONE;
            end
          end
          default: ;
        endcase
        st_left--;
        if (st_left == 0) begin
          v = st_neg ? -st_accum : st_accum;
          case (st_target)
            TGT_THROTTLE: thr_now   = (v > floor_thr) ? v : floor_thr;
            TGT_ROLL:     roll_now  = v;
            TGT_PITCH:    pitch_now = v;
            TGT_FLOOR:    floor_thr = v;
            default: ;
          endcase
          st_target = TGT_NONE;
        end
      end else begin
        case (s.ch)
          ChArm: begin
            st_armed = !st_armed;
            thr_now  = int'(cfg_now.arm_throttle);
          end
          ChClear: clr = 1'b1;
          ChCenter: begin
            centre_pitch = int'(s.rp);
            centre_roll  = int'(s.rr);
            pitch_now    = int'(s.rp);
            roll_now     = int'(s.rr);
          end
          ChThr:   open_arg(TGT_THROTTLE);
          ChRoll:  open_arg(TGT_ROLL);
          ChPitch: open_arg(TGT_PITCH);
          ChFloor: open_arg(TGT_FLOOR);
          ChNorth: begin st_dirs[0] = 1'b1; st_hold = 0; end
          ChEast:  begin st_dirs[1] = 1'b1; st_hold = 0; end
          ChSouth: begin st_dirs[2] = 1'b1; st_hold = 0; end
          ChWest:  begin st_dirs[3] = 1'b1; st_hold = 0; end
          default: ;
        endcase
      end
    end else begin
      // Loop tick: deflect from the centres, then age the direction flags.
      adj       = int'(cfg_now.adjustment);
      pitch_now = centre_pitch + (int'(st_dirs[2]) - int'(st_dirs[0])) * adj;
      roll_now  = centre_roll + (int'(st_dirs[3]) - int'(st_dirs[1])) * adj;
      if (st_hold > int'(cfg_now.hold_limit)) begin
        st_dirs = 4'd0;
        st_hold = 0;
      end
      if (st_hold < int'(CountMax)) st_hold++;
    end
    r.armed       = st_armed;
    r.throttle    = 15'(thr_now);
    r.pitch       = 15'(pitch_now);
    r.roll        = 15'(roll_now);
    r.clear_store = clr;
    r.directions  = st_dirs;
    return r;
  endfunction

  // Builds one row of the directed table.
  function automatic step_t row(input logic mode, input logic [7:0] ch, input int rp,
                                input int rr, input logic typed, input logic armed,
                                input int thr, input int p, input int r, input logic clr,
                                input logic [3:0] dirs);
    step_t s;
    s.mode             = mode;
    s.ch               = ch;
    s.rp               = 12'(rp);
    s.rr               = 12'(rr);
    s.typed            = typed;
    s.want.armed       = armed;
    s.want.throttle    = 15'(thr);
    s.want.pitch       = 15'(p);
    s.want.roll        = 15'(r);
    s.want.clear_store = clr;
    s.want.directions  = dirs;
    return s;
  endfunction

  // Cycles to wait before the next transfer on one side. Now and then a
  // calm stretch with no waiting at all is started.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 6) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
               $time, what, results_seen, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Request side. Every task starts by waiting for a falling edge, so each
  // input changes at most once per falling edge. A request stays presented
  // until the rising edge at which the block takes it; the predictor then
  // runs straight away, so the generator always sees the current state.
  // --------------------------------------------------------------------------
  task automatic send_request(input step_t s);
    int     gap;
    stick_t predicted;
    gap = draw_gap(src_calm);
    @(negedge clk);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.mode     <= s.mode;
    cmd.rx_byte  <= s.ch;
    cmd.rc_pitch <= s.rp;
    cmd.rc_roll  <= s.rr;
    do @(posedge clk); while (!cmd.ready);
    predicted = predict_stick(s);
    stick_expected.push_back(s.typed ? s.want : predicted);
  endtask

  task automatic send_byte(input logic [7:0] ch);
    step_t s;
    s      = '0;
    s.ch   = ch;
    s.rp   = 12'($urandom_range(0, 4095));
    s.rr   = 12'($urandom_range(0, 4095));
    send_request(s);
  endtask

  task automatic send_tick();
    step_t s;
    s      = '0;
    s.mode = 1'b1;
    s.ch   = 8'($urandom_range(0, 255));
    s.rp   = 12'($urandom_range(0, 4095));
    s.rr   = 12'($urandom_range(0, 4095));
    send_request(s);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    cmd.valid <= 1'b0;
  endtask

  // Writes one register over the APB-style port and reads it straight back.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    case (idx)
      RegAdjustment: begin
        cfg_now.adjustment = value[9:0];
        want = 32'(value[9:0]);
      end
      RegHoldLimit: begin
        cfg_now.hold_limit = value[15:0];
        want = 32'(value[15:0]);
      end
      default: begin
        cfg_now.arm_throttle = value[11:0];
        want = 32'(value[11:0]);
      end
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", int'(prdata), int'(want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Four argument characters with random content: mostly a plausible number
  // (optional white space, optional sign, digits), sometimes broken by a
  // second sign or a stray byte.
  task automatic send_argument();
    int          r;
    logic [7:0]  c;
    for (int k = 0; k < ArgDigits; k++) begin
      if ($urandom_range(0, 9) == 0) send_tick();
      r = $urandom_range(0, 99);
      if (k == 0 && r < 20)
        c = (r < 10) ? ChSpace : ChTab + 8'($urandom_range(0, 4));
      else if (k < 2 && r < 40)
        c = (r < 30) ? ChMinus : ChPlus;
      else if (r < 94)
        c = ChZero + 8'($urandom_range(0, 9));
      else
        c = 8'($urandom_range(0, 255));
      send_byte(c);
    end
  endtask

  // One random phase. Most of the traffic is well-formed: ticks, command
  // letters and complete arguments (arming first if need be); the rest is
  // arbitrary bytes, which do not count towards the quota.
  task automatic run_random_phase(input int quota);
    int         sent;
    int         kind;
    logic [7:0] c;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_tick();
        sent++;
      end else if (kind < 55) begin
        case ($urandom_range(0, 12))
          0:       c = ChArm;
          1, 2:    c = ChClear;
          3, 4:    c = ChCenter;
          5, 6:    c = ChNorth;
          7, 8:    c = ChEast;
          9, 10:   c = ChSouth;
          default: c = ChWest;
        endcase
        send_byte(c);
        sent++;
      end else if (kind < 90) begin
        if (!st_armed && $urandom_range(0, 9) != 0) begin
          send_byte(ChArm);
          sent++;
        end
        case ($urandom_range(0, 3))
          0:       c = ChThr;
          1:       c = ChRoll;
          2:       c = ChPitch;
          default: c = ChFloor;
        endcase
        send_byte(c);
        send_argument();
        sent += 1 + ArgDigits;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls for a random number of cycles before
  // each result, then holds ready high until the result is taken.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int wait_n;
    stick.ready = 1'b0;
    forever begin
      @(negedge clk);
      wait_n = draw_gap(sink_calm);
      if (wait_n > 0) begin
        stick.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      stick.ready <= 1'b1;
      do @(posedge clk); while (!(stick.valid && !rst));
    end
  end

  // Every result taken is checked against the oldest prediction. Values are
  // sampled at the rising edge, before the block updates its outputs.
  always @(posedge clk) begin : result_check
    stick_t got;
    stick_t want;
    if (!rst && stick.valid && stick.ready) begin
      got.armed       = stick.armed;
      got.throttle    = stick.throttle;
      got.pitch       = stick.pitch;
      got.roll        = stick.roll;
      got.clear_store = stick.clear_store;
      got.directions  = stick.directions;
      if (stick_expected.size() == 0) begin
        report_mismatch("unexpected result", int'(got.throttle), 0);
      end else begin
        want = stick_expected.pop_front();
        if (got.armed !== want.armed)
          report_mismatch("armed", int'(got.armed), int'(want.armed));
        if (got.throttle !== want.throttle)
          report_mismatch("throttle", int'(got.throttle), int'(want.throttle));
        if (got.pitch !== want.pitch)
          report_mismatch("pitch", int'(got.pitch), int'(want.pitch));
        if (got.roll !== want.roll)
          report_mismatch("roll", int'(got.roll), int'(want.roll));
        if (got.clear_store !== want.clear_store)
          report_mismatch("clear_store", int'(got.clear_store), int'(want.clear_store));
        if (got.directions !== want.directions)
          report_mismatch("directions", int'(got.directions), int'(want.directions));
      end
      results_seen++;
    end
  end

  // Watchdog: the run is abandoned if nothing moves on either channel or on
  // the register port for too long.
  always @(posedge clk) begin
    if (rst || psel || (cmd.valid && cmd.ready) || (stick.valid && stick.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_flow
    logic [31:0] adj_val;
    logic [31:0] hold_val;
    logic [31:0] arm_val;

    // All inputs start at known values while reset is held.
    cmd.valid    = 1'b0;
    cmd.mode     = 1'b0;
    cmd.rx_byte  = 8'd0;
    cmd.rc_pitch = 12'd0;
    cmd.rc_roll  = 12'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 4'd0;
    pwdata       = 32'd0;

    // Directed table, run with the reset register values. Rows with the
    // typed flag carry an expectation that follows directly from the
    // specification; the argument rows in between rely on the predictor.
    //                       mode  byte        pitch roll  typed armd thr   pitch roll clr dirs
    // A tick straight after reset shows the reset values untouched.
    directed_steps[0]  = row(1'b1, 8'hFF,      0,    0,    1'b1, 0, 1100, 1502, 1502, 0, 4'h0);
    // The store-clear flag is one-shot.
    directed_steps[1]  = row(1'b0, ChClear,    0,    0,    1'b1, 0, 1100, 1502, 1502, 1, 4'h0);
    // An argument letter is ignored while disarmed.
    directed_steps[2]  = row(1'b0, ChThr,      0,    0,    1'b1, 0, 1100, 1502, 1502, 0, 4'h0);
    directed_steps[3]  = row(1'b0, ChArm,      0,    0,    1'b1, 1, 1100, 1502, 1502, 0, 4'h0);
    // Centre latch at the channel extremes.
    directed_steps[4]  = row(1'b0, ChCenter,   4095, 0,    1'b1, 1, 1100, 4095, 0,    0, 4'h0);
    directed_steps[5]  = row(1'b0, ChNorth,    0,    0,    1'b1, 1, 1100, 4095, 0,    0, 4'h1);
    directed_steps[6]  = row(1'b0, ChEast,     0,    0,    1'b1, 1, 1100, 4095, 0,    0, 4'h3);
    directed_steps[7]  = row(1'b0, ChSouth,    0,    0,    1'b1, 1, 1100, 4095, 0,    0, 4'h7);
    directed_steps[8]  = row(1'b0, ChWest,     0,    0,    1'b1, 1, 1100, 4095, 0,    0, 4'hF);
    // Opposite directions cancel, so the tick leaves the centres in place.
    directed_steps[9]  = row(1'b1, 8'h00,      0,    0,    1'b1, 1, 1100, 4095, 0,    0, 4'hF);
    // Largest argument value: four digits.
    directed_steps[10] = row(1'b0, ChPitch,    0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[11] = row(1'b0, ChNine,     0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[12] = row(1'b0, ChNine,     0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[13] = row(1'b0, ChNine,     0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[14] = row(1'b0, ChNine,     0,    0,    1'b1, 1, 1100, 9999, 0,    0, 4'hF);
    // Leading white space then a command letter: no digits, the floor becomes
    // zero and the letter inside the argument does not raise clear_store.
    directed_steps[15] = row(1'b0, ChFloor,    0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[16] = row(1'b0, ChSpace,    0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[17] = row(1'b0, ChTab,      0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[18] = row(1'b0, ChCr,       0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[19] = row(1'b0, ChClear,    0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    // A negative throttle argument ended by a command letter is floored at
    // the new floor of zero; the letter sets no direction.
    directed_steps[20] = row(1'b0, ChThr,      0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[21] = row(1'b0, ChMinus,    0,    0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[22] = row(1'b0, ChZero + 8'd1, 0, 0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[23] = row(1'b0, ChZero + 8'd2, 0, 0,    1'b0, 0, 0,    0,    0,    0, 4'h0);
    directed_steps[24] = row(1'b0, ChNorth,    0,    0,    1'b1, 1, 0,    9999, 0,    0, 4'hF);

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 25; i++) send_request(directed_steps[i]);

    // Random phases. The registers are rewritten only once every result of
    // the previous phase has come back; every request yields exactly one
    // result, so an empty store of predictions means the block is idle.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      stop_requests();
      while (stick_expected.size() != 0) @(posedge clk);
      case (ph)
        0: begin
          adj_val  = 32'd0;
          hold_val = 32'd0;
          arm_val  = 32'd0;
        end
        1: begin
          adj_val  = 32'd1023;
          hold_val = 32'd65535;
          arm_val  = 32'd4095;
        end
        default: begin
          adj_val  = 32'($urandom_range(0, 1023));
          // Small limits mostly, so that the flags are seen to expire.
          hold_val = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 65535))
                                                 : 32'($urandom_range(0, 24));
          arm_val  = 32'($urandom_range(0, 4095));
        end
      endcase
      write_reg(RegAdjustment, adj_val);
      write_reg(RegHoldLimit, hold_val);
      write_reg(RegArmThrottle, arm_val);
      run_random_phase(PhaseItems);
    end

    // Wait for the last results (the watchdog bounds this), then a few more
    // cycles so that any spurious extra result is caught.
    stop_requests();
    while (stick_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
